>>> hdl/hqt_pkg.sv
// Shared types and constants for the hierarchical quota tracker.
// No dependencies; every other file depends on this package.
`default_nettype none

package hqt_pkg;

  // Default build values
  localparam int NodesDef   = 4;
  localparam int AmountWDef = 32;

  // Fixed field widths
  localparam int MaxNodes = 4;
  localparam int NodeW    = 2;
  localparam int AmtInW   = 32;
  localparam int LimitW   = 32;
  localparam int PmapW    = 16;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_PARENT_MAP = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_LIMIT0     = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_LIMIT1     = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_LIMIT2     = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_LIMIT3     = 3'd4;

  // Request opcodes
  localparam logic OP_ACQUIRE = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef logic [MaxNodes-1:0][LimitW-1:0] limit_vec_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_DONE
  } walk_state_e;

  typedef enum logic {
    PASS_CHECK,
    PASS_COMMIT
  } walk_pass_e;

  // Control of the node memory
  typedef struct packed {
    logic             re;
    logic [NodeW-1:0] raddr;
    logic             we;
    logic [NodeW-1:0] waddr;
  } mem_ctrl_t;

endpackage

`default_nettype wire

>>> hdl/hqt_req_if.sv
// Request channel of the quota tracker: valid/ready plus op, node, amount.
// Depends on hqt_pkg for field widths.
`default_nettype none

interface hqt_req_if;
  logic                        valid;
  logic                        ready;
  logic                        op;
  logic [hqt_pkg::NodeW-1:0]   node;
  logic [hqt_pkg::AmtInW-1:0]  amount;

  modport source(output valid, output op, output node, output amount, input ready);
  modport sink(input valid, input op, input node, input amount, output ready);
endinterface

`default_nettype wire

>>> hdl/hqt_rsp_if.sv
// Result channel of the quota tracker: valid/ready plus grant, underflow, use, peak.
// Depends on hqt_pkg for field widths.
`default_nettype none

interface hqt_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        granted;
  logic                        underflow;
  logic [hqt_pkg::LimitW-1:0]  use_after;
  logic [hqt_pkg::LimitW-1:0]  peak_after;

  modport source(output valid, output granted, output underflow, output use_after,
                 output peak_after, input ready);
  modport sink(input valid, input granted, input underflow, input use_after,
               input peak_after, output ready);
endinterface

`default_nettype wire

>>> hdl/hqt_mem.sv
// Node memory: {peak, use} per node, one read and one write port, registered read.
// Depends on hqt_pkg; entries never written read as zero via per-entry valid bits.
`default_nettype none

module hqt_mem #(
  parameter int NODES        = hqt_pkg::NodesDef,
  parameter int AMOUNT_WIDTH = hqt_pkg::AmountWDef
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire hqt_pkg::mem_ctrl_t        ctrl_i,
  input  wire logic [2*AMOUNT_WIDTH-1:0] wdata_i,
  output logic      [2*AMOUNT_WIDTH-1:0] rdata_o
);
  import hqt_pkg::*;

  localparam int IdxW = (NODES > 1) ? $clog2(NODES) : 1;

  logic [2*AMOUNT_WIDTH-1:0] mem [NODES];
  logic [NODES-1:0]          valid_q;
  logic [2*AMOUNT_WIDTH-1:0] rdata_q;
  logic [IdxW-1:0]           raddr;
  logic [IdxW-1:0]           waddr;

  assign raddr = ctrl_i.raddr[IdxW-1:0];
  assign waddr = ctrl_i.waddr[IdxW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (ctrl_i.we) begin
      valid_q[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.we) begin
      mem[waddr] <= wdata_i;
    end
    if (ctrl_i.re) begin
      rdata_q <= valid_q[raddr] ? mem[raddr] : '0;
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> hdl/hqt_walk.sv
// Chain-walk sequencer: check pass, commit pass, result register.
// Depends on hqt_pkg; drives the node memory in hqt_mem.
`default_nettype none

module hqt_walk #(
  parameter int NODES        = hqt_pkg::NodesDef,
  parameter int AMOUNT_WIDTH = hqt_pkg::AmountWDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // request side
  input  wire logic                          req_valid_i,
  output logic                               req_ready_o,
  input  wire logic                          req_op_i,
  input  wire logic [hqt_pkg::NodeW-1:0]     req_node_i,
  input  wire logic [hqt_pkg::AmtInW-1:0]    req_amount_i,
  // result side
  output logic                               rsp_valid_o,
  input  wire logic                          rsp_ready_i,
  output logic                               rsp_granted_o,
  output logic                               rsp_underflow_o,
  output logic      [hqt_pkg::LimitW-1:0]    rsp_use_o,
  output logic      [hqt_pkg::LimitW-1:0]    rsp_peak_o,
  // configuration
  input  wire logic [hqt_pkg::PmapW-1:0]     parent_map_i,
  input  wire hqt_pkg::limit_vec_t           limit_i,
  // node memory
  output hqt_pkg::mem_ctrl_t                 mem_ctrl_o,
  output logic      [2*AMOUNT_WIDTH-1:0]     mem_wdata_o,
  input  wire logic [2*AMOUNT_WIDTH-1:0]     mem_rdata_i
);
  import hqt_pkg::*;

  localparam int AW   = AMOUNT_WIDTH;
  localparam int CmpW = (AW > LimitW) ? AW : LimitW;
  localparam logic [2:0] NodesC = 3'(NODES);

  walk_state_e         state_q, state_d;
  walk_pass_e          pass_q, pass_d;
  logic                op_q, op_d;
  logic [NodeW-1:0]    node_q, node_d;
  logic [AW-1:0]       amt_q, amt_d;
  logic [NodeW-1:0]    ptr_q, ptr_d;
  logic [MaxNodes-1:0] seen_q, seen_d;
  logic [2:0]          cnt_q, cnt_d;
  logic                under_q, under_d;
  logic                gnt_q, gnt_d;
  logic [AW-1:0]       res_use_q, res_use_d;
  logic [AW-1:0]       res_peak_q, res_peak_d;

  logic                rsp_valid_q, rsp_valid_d;
  logic                rsp_granted_q;
  logic                rsp_under_q;
  logic [LimitW-1:0]   rsp_use_q;
  logic [LimitW-1:0]   rsp_peak_q;
  logic                out_load;

  // datapath of one chain step
  logic [AW-1:0]       cur_use, cur_peak;
  logic [AW:0]         sum_w;
  logic                chk_ok;
  logic                short_rel;
  logic [AW-1:0]       new_use, new_peak;
  logic [3:0]          nib;
  logic [NodeW-1:0]    par;
  logic [MaxNodes-1:0] seen_nx;
  logic [2:0]          cnt_nx;
  logic                cont;

  assign cur_use  = mem_rdata_i[AW-1:0];
  assign cur_peak = mem_rdata_i[2*AW-1:AW];
  assign sum_w    = {1'b0, cur_use} + {1'b0, amt_q};
  assign chk_ok   = !sum_w[AW] && !(CmpW'(sum_w[AW-1:0]) > CmpW'(limit_i[ptr_q]));
  assign short_rel = amt_q > cur_use;

  always_comb begin
    if (op_q == OP_ACQUIRE) begin
      new_use  = sum_w[AW-1:0];
      new_peak = (sum_w[AW-1:0] > cur_peak) ? sum_w[AW-1:0] : cur_peak;
    end else begin
      new_use  = short_rel ? '0 : cur_use - amt_q;
      new_peak = cur_peak;
    end
  end

  // next chain node: stop at no parent, out of range, revisit or step limit
  assign nib     = parent_map_i[{ptr_q, 2'b00} +: 4];
  assign par     = nib[1:0];
  assign seen_nx = seen_q | (MaxNodes'(1) << ptr_q);
  assign cnt_nx  = cnt_q + 3'd1;
  assign cont    = nib[3] && ({1'b0, par} < NodesC) && !seen_nx[par] && (cnt_nx < NodesC);

  assign mem_wdata_o = {new_peak, new_use};

  always_comb begin
    state_d    = state_q;
    pass_d     = pass_q;
    op_d       = op_q;
    node_d     = node_q;
    amt_d      = amt_q;
    ptr_d      = ptr_q;
    seen_d     = seen_q;
    cnt_d      = cnt_q;
    under_d    = under_q;
    gnt_d      = gnt_q;
    res_use_d  = res_use_q;
    res_peak_d = res_peak_q;
    req_ready_o = 1'b0;
    out_load    = 1'b0;
    mem_ctrl_o  = '0;

    unique case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          op_d     = req_op_i;
          node_d   = req_node_i;
          amt_d    = AW'(req_amount_i);
          ptr_d    = req_node_i;
          seen_d   = '0;
          cnt_d    = '0;
          under_d  = 1'b0;
          gnt_d    = 1'b0;
          pass_d   = (req_op_i == OP_ACQUIRE) ? PASS_CHECK : PASS_COMMIT;
          if ({1'b0, req_node_i} < NodesC) begin
            state_d = ST_READ;
          end else begin
            // ignored request: all-zero result
            res_use_d  = '0;
            res_peak_d = '0;
            state_d    = ST_DONE;
          end
        end
      end
      ST_READ: begin
        mem_ctrl_o.re    = 1'b1;
        mem_ctrl_o.raddr = ptr_q;
        state_d          = ST_EVAL;
      end
      ST_EVAL: begin
        seen_d = seen_nx;
        cnt_d  = cnt_nx;
        if (pass_q == PASS_CHECK) begin
          if (cnt_q == '0) begin
            res_use_d  = cur_use;
            res_peak_d = cur_peak;
          end
          priority if (!chk_ok) begin
            gnt_d   = 1'b0;
            state_d = ST_DONE;
          end else if (cont) begin
            ptr_d   = par;
            state_d = ST_READ;
          end else begin
            // all checks passed: restart the walk to commit
            pass_d  = PASS_COMMIT;
            ptr_d   = node_q;
            seen_d  = '0;
            cnt_d   = '0;
            state_d = ST_READ;
          end
        end else begin
          mem_ctrl_o.we    = 1'b1;
          mem_ctrl_o.waddr = ptr_q;
          if (cnt_q == '0) begin
            res_use_d  = new_use;
            res_peak_d = new_peak;
          end
          if (op_q == OP_RELEASE && short_rel) begin
            under_d = 1'b1;
          end
          if (cont) begin
            ptr_d   = par;
            state_d = ST_READ;
          end else begin
            gnt_d   = 1'b1;
            state_d = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (!rsp_valid_q || rsp_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign rsp_valid_d = out_load | (rsp_valid_q & !rsp_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pass_q      <= PASS_CHECK;
      ptr_q       <= '0;
      seen_q      <= '0;
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pass_q      <= pass_d;
      ptr_q       <= ptr_d;
      seen_q      <= seen_d;
      cnt_q       <= cnt_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    node_q     <= node_d;
    amt_q      <= amt_d;
    under_q    <= under_d;
    gnt_q      <= gnt_d;
    res_use_q  <= res_use_d;
    res_peak_q <= res_peak_d;
    if (out_load) begin
      rsp_granted_q <= gnt_q;
      rsp_under_q   <= under_q;
      rsp_use_q     <= LimitW'(res_use_q);
      rsp_peak_q    <= LimitW'(res_peak_q);
    end
  end

  assign rsp_valid_o     = rsp_valid_q;
  assign rsp_granted_o   = rsp_granted_q;
  assign rsp_underflow_o = rsp_under_q;
  assign rsp_use_o       = rsp_use_q;
  assign rsp_peak_o      = rsp_peak_q;

endmodule

`default_nettype wire

>>> hdl/hierarchical_quota_tracker_core.sv
// Top level of the hierarchical quota tracker: configuration registers,
// chain-walk sequencer (hqt_walk) and node memory (hqt_mem). Depends on hqt_pkg.
`default_nettype none

// Keeps a use and a peak counter for up to NODES quota nodes arranged in a
// tree by parent_map. An acquire request walks from the named node to the
// root twice: a check pass that verifies no node overflows AMOUNT_WIDTH bits
// or exceeds its limit, then, only if every node passed, a commit pass that
// adds the amount and raises each peak. A release request makes the commit
// pass alone, subtracting with clamp at zero and flagging underflow. The
// walk stops at a node without a valid parent, at a node already visited,
// or after NODES nodes. Each chain node passes through a READ and an EVAL
// state per pass because the single node memory has a registered read;
// the commit pass writes the node back in EVAL. A request naming a node
// outside the tree returns all zeros. One request is in flight at a time;
// the next request is taken while the previous result still waits in the
// output register. Counters start at zero after reset with no clearing pass.
// Write configuration only while no request is in flight; indexes beyond
// the last limit register are ignored.
module hierarchical_quota_tracker_core #(
  parameter int NODES        = hqt_pkg::NodesDef,
  parameter int AMOUNT_WIDTH = hqt_pkg::AmountWDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  hqt_req_if.sink                            req,
  hqt_rsp_if.source                          rsp,
  input  wire logic                          cfg_we_i,
  input  wire logic [hqt_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [hqt_pkg::CfgDataW-1:0]  cfg_data_i
);
  import hqt_pkg::*;

  logic [PmapW-1:0]          parent_map_q;
  limit_vec_t                limit_q;
  mem_ctrl_t                 mem_ctrl;
  logic [2*AMOUNT_WIDTH-1:0] mem_wdata;
  logic [2*AMOUNT_WIDTH-1:0] mem_rdata;

  // Configuration registers: parent map resets to "no parents", limits to all ones.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parent_map_q <= '0;
      limit_q      <= '1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PARENT_MAP: parent_map_q <= cfg_data_i[PmapW-1:0];
        CFG_LIMIT0:     limit_q[0]   <= cfg_data_i[LimitW-1:0];
        CFG_LIMIT1:     limit_q[1]   <= cfg_data_i[LimitW-1:0];
        CFG_LIMIT2:     limit_q[2]   <= cfg_data_i[LimitW-1:0];
        CFG_LIMIT3:     limit_q[3]   <= cfg_data_i[LimitW-1:0];
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  // Sequencer: owns the request handshake, both passes and the result register.
  hqt_walk #(
    .NODES       (NODES),
    .AMOUNT_WIDTH(AMOUNT_WIDTH)
  ) u_walk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_valid_i    (req.valid),
    .req_ready_o    (req.ready),
    .req_op_i       (req.op),
    .req_node_i     (req.node),
    .req_amount_i   (req.amount),
    .rsp_valid_o    (rsp.valid),
    .rsp_ready_i    (rsp.ready),
    .rsp_granted_o  (rsp.granted),
    .rsp_underflow_o(rsp.underflow),
    .rsp_use_o      (rsp.use_after),
    .rsp_peak_o     (rsp.peak_after),
    .parent_map_i   (parent_map_q),
    .limit_i        (limit_q),
    .mem_ctrl_o     (mem_ctrl),
    .mem_wdata_o    (mem_wdata),
    .mem_rdata_i    (mem_rdata)
  );

  // Node memory: holds {peak, use} of every node.
  hqt_mem #(
    .NODES       (NODES),
    .AMOUNT_WIDTH(AMOUNT_WIDTH)
  ) u_mem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mem_ctrl),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

`ifndef SYNTHESIS
  // A read-modify-write step never reads and writes the memory in one cycle.
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_ctrl.we |-> !mem_ctrl.re)
    else $error("node memory read and written in the same cycle");

  // The cycle after a request is taken never writes the memory.
  a_no_write_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req.valid && req.ready) |=> !mem_ctrl.we)
    else $error("memory written right after request acceptance");

  // A refused request never reports underflow.
  a_refused_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp.valid && !rsp.granted) |-> !rsp.underflow)
    else $error("underflow flagged on a refused request");

  // Every memory write carries a walk address that lies in the tree.
  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_ctrl.we |-> ({1'b0, mem_ctrl.waddr} < 3'(NODES)))
    else $error("memory write outside the node range");
`endif

endmodule

`default_nettype wire

>>> test/hqt_quota_checker.sv
`timescale 1ns / 100ps
// Checker for the hierarchical quota tracker: watches the request, result and
// configuration ports, predicts each result in order and compares it.
// Depends on hqt_pkg for field widths, opcodes and register indexes.
`default_nettype none

module hqt_quota_checker (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          req_valid_i,
  input  wire logic                          req_ready_i,
  input  wire logic                          req_op_i,
  input  wire logic [hqt_pkg::NodeW-1:0]     req_node_i,
  input  wire logic [hqt_pkg::AmtInW-1:0]    req_amount_i,
  input  wire logic                          rsp_valid_i,
  input  wire logic                          rsp_ready_i,
  input  wire logic                          rsp_granted_i,
  input  wire logic                          rsp_underflow_i,
  input  wire logic [hqt_pkg::LimitW-1:0]    rsp_use_i,
  input  wire logic [hqt_pkg::LimitW-1:0]    rsp_peak_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [hqt_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [hqt_pkg::CfgDataW-1:0]  cfg_data_i,
  output int                                 fail_count_o,
  output int                                 pending_o
);
  import hqt_pkg::*;

  typedef logic [LimitW-1:0] quota_t;

  typedef struct packed {
    logic   granted;
    logic   underflow;
    quota_t use_after;
    quota_t peak_after;
  } quota_result_t;

  quota_t           use_q   [MaxNodes];
  quota_t           peak_q  [MaxNodes];
  quota_t           limit_q [MaxNodes];
  logic [PmapW-1:0] parent_q;

  quota_result_t    outcome_q [$];
  int               fails;

  // Apply one request to the shadow counters and return the result it yields.
  function automatic quota_result_t account_request(input logic op,
                                                    input logic [NodeW-1:0] node,
                                                    input quota_t amt);
    logic [NodeW-1:0]    path [MaxNodes];
    logic [MaxNodes-1:0] visited;
    logic [NodeW-1:0]    cur;
    logic [3:0]          nib;
    logic                more;
    logic                fits;
    logic [LimitW:0]     sum;
    int                  depth;
    int                  i;
    quota_result_t       res;

    res     = '0;
    depth   = 0;
    visited = '0;
    cur     = node;
    more    = 1'b1;
    // collect the chain toward the root, each node once, at most NodesDef long
    while (more && depth < NodesDef) begin
      if (int'(cur) >= NodesDef || visited[cur]) begin
        more = 1'b0;
      end else begin
        visited[cur] = 1'b1;
        path[depth]  = cur;
        depth++;
        nib = parent_q[4*int'(cur) +: 4];
        if (nib[3]) cur = nib[1:0];
        else more = 1'b0;
      end
    end

    if (op == OP_ACQUIRE) begin
      fits = 1'b1;
      for (i = 0; i < depth; i++) begin
        sum = {1'b0, use_q[path[i]]} + {1'b0, amt};
        if (sum[LimitW] || sum[LimitW-1:0] > limit_q[path[i]]) fits = 1'b0;
      end
      if (fits) begin
        for (i = 0; i < depth; i++) begin
          use_q[path[i]] = use_q[path[i]] + amt;
          if (use_q[path[i]] > peak_q[path[i]]) peak_q[path[i]] = use_q[path[i]];
        end
        res.granted = 1'b1;
      end
    end else begin
      for (i = 0; i < depth; i++) begin
        if (amt > use_q[path[i]]) begin
          use_q[path[i]] = '0;
          res.underflow  = 1'b1;
        end else begin
          use_q[path[i]] = use_q[path[i]] - amt;
        end
      end
      res.granted = 1'b1;
    end
    res.use_after  = use_q[node];
    res.peak_after = peak_q[node];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    quota_result_t want;
    quota_result_t got;
    if (!rst_ni) begin
      for (int k = 0; k < MaxNodes; k++) begin
        use_q[k]   = '0;
        peak_q[k]  = '0;
        limit_q[k] = '1;
      end
      parent_q = '0;
      outcome_q.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PARENT_MAP: parent_q   = cfg_data_i[PmapW-1:0];
          CFG_LIMIT0:     limit_q[0] = cfg_data_i[LimitW-1:0];
          CFG_LIMIT1:     limit_q[1] = cfg_data_i[LimitW-1:0];
          CFG_LIMIT2:     limit_q[2] = cfg_data_i[LimitW-1:0];
          CFG_LIMIT3:     limit_q[3] = cfg_data_i[LimitW-1:0];
          default: ;
        endcase
      end

      // pop before push: a result never belongs to the request taken this edge
      if (rsp_valid_i && rsp_ready_i) begin
        got = '{rsp_granted_i, rsp_underflow_i, rsp_use_i, rsp_peak_i};
        if (outcome_q.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t: result with no request outstanding: granted=%0b underflow=%0b use=%0h peak=%0h",
                     $realtime, got.granted, got.underflow, got.use_after, got.peak_after);
        end else begin
          want = outcome_q.pop_front();
          if (got.granted !== want.granted || got.underflow !== want.underflow ||
              got.use_after !== want.use_after || got.peak_after !== want.peak_after) begin
            fails++;
            if (fails <= 10)
              $display("%0t: result mismatch: expected granted=%0b underflow=%0b use=%0h peak=%0h, got granted=%0b underflow=%0b use=%0h peak=%0h",
                       $realtime, want.granted, want.underflow, want.use_after, want.peak_after,
                       got.granted, got.underflow, got.use_after, got.peak_after);
          end
        end
      end

      if (req_valid_i && req_ready_i)
        outcome_q.push_back(account_request(req_op_i, req_node_i, req_amount_i));

      fail_count_o <= fails;
      pending_o    <= outcome_q.size();
    end
  end

endmodule

`default_nettype wire

>>> test/tb_hierarchical_quota_tracker_core.sv
`timescale 1ns / 100ps
// Testbench top for hierarchical_quota_tracker_core: drives requests and
// configuration, paces the result side and reports the verdict.
// Depends on hqt_pkg, hqt_req_if, hqt_rsp_if and hqt_quota_checker.
`default_nettype none

module tb_hierarchical_quota_tracker_core;
  import hqt_pkg::*;

  typedef logic [LimitW-1:0] quota_t;

  // Indexes past the last limit register; writes there must leave no trace.
  localparam logic [CfgIdxW-1:0] CFG_UNUSED_FIRST = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_UNUSED_LAST  = 3'd7;

  // Settle a little beyond the longest request walk.
  localparam int SETTLE_CYCLES   = 24;
  // Receiver hold-off long enough to back the tracker up into the sender.
  localparam int RSP_HOLD_CYCLES = 300;
  localparam int PHASE_REQUESTS  = 60;
  localparam int RANDOM_PHASES   = 8;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;
  logic                rsp_hold_req;
  int                  fail_count;
  int                  pending;

  hqt_req_if req_bus ();
  hqt_rsp_if rsp_bus ();

  hierarchical_quota_tracker_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req        (req_bus),
    .rsp        (rsp_bus),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  hqt_quota_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_valid_i     (req_bus.valid),
    .req_ready_i     (req_bus.ready),
    .req_op_i        (req_bus.op),
    .req_node_i      (req_bus.node),
    .req_amount_i    (req_bus.amount),
    .rsp_valid_i     (rsp_bus.valid),
    .rsp_ready_i     (rsp_bus.ready),
    .rsp_granted_i   (rsp_bus.granted),
    .rsp_underflow_i (rsp_bus.underflow),
    .rsp_use_i       (rsp_bus.use_after),
    .rsp_peak_i      (rsp_bus.peak_after),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Idle stretch for either side: mostly none, often short, now and then long.
  function automatic int idle_span();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one request after a random gap and hold it until it is taken.
  // Valid stays high into the next request when no gap is drawn.
  task automatic send_request(input logic op, input logic [NodeW-1:0] node,
                              input quota_t amt);
    int gap;
    gap = idle_span();
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_bus.valid  <= 1'b1;
    req_bus.op     <= op;
    req_bus.node   <= node;
    req_bus.amount <= amt;
    do @(posedge clk_i); while (!req_bus.ready);
  endtask

  // Drop valid, wait for every outstanding result, then let the walk settle.
  task automatic settle_block();
    req_bus.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Hold the write enable across back-to-back writes; the caller drops it.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
  endtask

  // Reprogram the tree and all limits once the tracker is idle. Junk writes
  // to unused indexes go last so that any aliasing would stick.
  task automatic apply_setting(input logic [PmapW-1:0] pmap, input quota_t lim0,
                               input quota_t lim1, input quota_t lim2,
                               input quota_t lim3, input logic junk);
    settle_block();
    write_reg(CFG_PARENT_MAP, CfgDataW'(pmap));
    write_reg(CFG_LIMIT0, lim0);
    write_reg(CFG_LIMIT1, lim1);
    write_reg(CFG_LIMIT2, lim2);
    write_reg(CFG_LIMIT3, lim3);
    if (junk) begin
      write_reg(CFG_UNUSED_FIRST, 32'd1);
      write_reg(CFG_UNUSED_LAST, 32'd0);
    end
    cfg_we <= 1'b0;
  endtask

  // One random setting followed by a burst of requests. Amounts lean small so
  // that grants and refusals mix against the limits; full-width amounts and
  // the extremes come in often enough to reach overflow and underflow.
  task automatic run_random_phase(input logic extreme, input logic squeeze);
    logic [PmapW-1:0] pmap;
    quota_t           lim [MaxNodes];
    logic             op;
    logic [NodeW-1:0] node;
    quota_t           amt;
    int               k;
    int               roll;

    pmap = extreme ? '1 : PmapW'($urandom());
    for (k = 0; k < MaxNodes; k++) begin
      roll = $urandom_range(0, 7);
      if (extreme)       lim[k] = '1;
      else if (roll == 0) lim[k] = '0;
      else if (roll == 1) lim[k] = '1;
      else if (roll < 4)  lim[k] = $urandom();
      else                lim[k] = $urandom_range(1, 2000);
    end
    apply_setting(pmap, lim[0], lim[1], lim[2], lim[3], 1'b0);

    // drain every node now and then so the new limits start from empty
    if ($urandom_range(0, 1) == 1)
      for (k = 0; k < MaxNodes; k++) send_request(OP_RELEASE, NodeW'(k), '1);

    if (squeeze) rsp_hold_req <= 1'b1;

    for (k = 0; k < PHASE_REQUESTS; k++) begin
      op   = ($urandom_range(0, 99) < 55) ? OP_ACQUIRE : OP_RELEASE;
      node = NodeW'($urandom_range(0, MaxNodes - 1));
      roll = $urandom_range(0, 99);
      if (roll < 60)      amt = $urandom_range(0, 300);
      else if (roll < 75) amt = $urandom_range(0, 3000);
      else if (roll < 90) amt = $urandom();
      else if (roll < 95) amt = '1;
      else                amt = '0;
      send_request(op, node, amt);
    end
  endtask

  // Result side: random ready pattern with long open runs, plus one long
  // hold-off when the stimulus asks for back-pressure.
  initial begin : result_sink
    int   span;
    logic held;
    held = 1'b0;
    rsp_bus.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (rsp_hold_req && !held) begin
        held = 1'b1;
        rsp_bus.ready <= 1'b0;
        repeat (RSP_HOLD_CYCLES) @(posedge clk_i);
      end
      span = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      rsp_bus.ready <= 1'b1;
      repeat (span) @(posedge clk_i);
      span = idle_span();
      if (span > 0) begin
        rsp_bus.ready <= 1'b0;
        repeat (span) @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    int ph;
    req_bus.valid  = 1'b0;
    req_bus.op     = OP_ACQUIRE;
    req_bus.node   = '0;
    req_bus.amount = '0;
    cfg_we         = 1'b0;
    cfg_idx        = CFG_PARENT_MAP;
    cfg_data       = '0;
    rsp_hold_req   = 1'b0;
    rst_ni         = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Flat tree, limits at reset: hit the 32-bit ceiling and the zero clamp.
    send_request(OP_ACQUIRE, 2'd0, '1);
    send_request(OP_ACQUIRE, 2'd0, 32'd1);          // would overflow: refuse
    send_request(OP_RELEASE, 2'd0, '1);             // peak must stay at max
    send_request(OP_RELEASE, 2'd0, 32'd5);          // below zero: clamp, flag
    send_request(OP_ACQUIRE, 2'd1, '0);
    send_request(OP_ACQUIRE, 2'd2, 32'h8000_0000);
    send_request(OP_ACQUIRE, 2'd3, 32'h7FFF_FFFF);
    send_request(OP_RELEASE, 2'd1, '0);

    // Tree 1->0, 2->1, 3->1 with tight limits; junk index writes at the end.
    apply_setting(16'h9980, 32'd100, 32'd60, 32'd30, '1, 1'b1);
    send_request(OP_RELEASE, 2'd2, '1);
    send_request(OP_RELEASE, 2'd3, '1);
    send_request(OP_ACQUIRE, 2'd2, 32'd20);
    send_request(OP_ACQUIRE, 2'd3, 32'd40);         // node 1 exactly at limit
    send_request(OP_ACQUIRE, 2'd3, 32'd1);          // parent over limit: refuse
    send_request(OP_ACQUIRE, 2'd0, 32'd40);
    send_request(OP_ACQUIRE, 2'd0, 32'd1);
    send_request(OP_RELEASE, 2'd3, 32'd50);         // clamp on 3, parents still drop

    // Parent cycles 0<->1 and 2<->3; node 2's entry carries the ignored bit.
    apply_setting(16'hAF89, '1, '1, '1, '1, 1'b0);
    send_request(OP_ACQUIRE, 2'd2, 32'd7);
    send_request(OP_ACQUIRE, 2'd0, 32'd3);
    send_request(OP_RELEASE, 2'd3, 32'd10);
    send_request(OP_ACQUIRE, 2'd1, '1);

    // Every limit at zero: only a zero amount on an empty chain fits.
    apply_setting('0, '0, '0, '0, '0, 1'b0);
    send_request(OP_ACQUIRE, 2'd1, '0);
    send_request(OP_RELEASE, 2'd1, '1);
    send_request(OP_ACQUIRE, 2'd1, '0);
    send_request(OP_ACQUIRE, 2'd1, 32'd1);

    // Random settings; one all-ones phase, one phase under back-pressure.
    for (ph = 0; ph < RANDOM_PHASES; ph++)
      run_random_phase(ph == 4, ph == 1);

    settle_block();
    if (fail_count == 0 && pending == 0) begin
      $display("tb_hierarchical_quota_tracker_core: PASS");
    end else begin
      $display("tb_hierarchical_quota_tracker_core: FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin : watchdog
    #3_000_000;
    $display("tb_hierarchical_quota_tracker_core: FAIL");
    $finish;
  end

endmodule

`default_nettype wire
